// ===== design/tilt_orientation_debouncer_top_assert.svh =====
// assertion macros used by the debouncer back end (tod_back)
`ifndef TILT_ORIENTATION_DEBOUNCER_TOP_ASSERT_SVH
`define TILT_ORIENTATION_DEBOUNCER_TOP_ASSERT_SVH

// clocked check, masked while reset is held
`define TOD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define TOD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tod_pkg.sv =====
`default_nettype none
package tod_pkg;

  // rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // register word indexes
  localparam logic REG_FLAT_THRESHOLD = 1'b0;
  localparam logic REG_DEBOUNCE_COUNT = 1'b1;

  // register widths and reset values
  localparam int unsigned THR_W    = 15;
  localparam int unsigned THR_SQ_W = 2 * THR_W;
  localparam int unsigned DEB_W    = 8;
  localparam logic [THR_W-1:0]    THR_RESET    = 15'd1843;
  localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = 30'd3396649;
  localparam logic [DEB_W-1:0]    DEB_RESET    = 8'd5;

  // decoupling queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // classified sample handed from front to back
  typedef struct packed {
    logic       flat;
    logic [1:0] quad;
  } tod_class_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [THR_SQ_W-1:0] thr_sq;
    logic [DEB_W-1:0]    debounce;
  } tod_cfg_t;

endpackage
`default_nettype wire

// ===== design/tilt_orientation_debouncer_top.sv =====
// throughput: one beat per cycle while out_ready lets the output drain; the squares, the flat compare and the
// debounce update each sit in their own stage, with a two-entry queue between
// reset: synchronous active-low; clears rotation, target and count,
// sets flat_threshold to 1843 and debounce_count to 5
`default_nettype none
module tilt_orientation_debouncer_top #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] in_gravity_x,
  input  wire logic signed [SAMPLE_BITS-1:0] in_gravity_y,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_rotation,
  output logic                               out_rotation_changed,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  tod_pkg::tod_cfg_t   cfg;
  tod_pkg::tod_class_t push_data, q_data;
  logic                q_push, q_full, q_valid, q_pop;

  // configuration registers
  tod_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // classification front
  tod_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_gravity_x (in_gravity_x),
    .in_gravity_y (in_gravity_y),
    .thr_sq       (cfg.thr_sq),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  // decoupling queue
  tod_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  // debounce back end
  tod_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_valid              (q_valid),
    .q_data               (q_data),
    .pop                  (q_pop),
    .debounce             (cfg.debounce),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_rotation         (out_rotation),
    .out_rotation_changed (out_rotation_changed)
  );

endmodule
`default_nettype wire

// ===== design/tod_regs.sv =====
`default_nettype none
module tod_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output tod_pkg::tod_cfg_t      cfg
);

  logic [tod_pkg::THR_W-1:0]    thr_r,    thr_nxt;
  logic [tod_pkg::THR_SQ_W-1:0] thr_sq_r, thr_sq_nxt;
  logic [tod_pkg::DEB_W-1:0]    deb_r,    deb_nxt;
  logic                         wr_en;
  logic [tod_pkg::THR_W-1:0]    wr_thr;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wr_thr = pwdata[tod_pkg::THR_W-1:0];

  // write decode, squared threshold kept alongside the threshold
  always_comb begin
    thr_nxt    = thr_r;
    thr_sq_nxt = thr_sq_r;
    deb_nxt    = deb_r;
    if (wr_en) begin
      unique case (paddr[2])
        tod_pkg::REG_FLAT_THRESHOLD: begin
          thr_nxt    = wr_thr;
          thr_sq_nxt = wr_thr * wr_thr;
        end
        tod_pkg::REG_DEBOUNCE_COUNT: begin
          deb_nxt = pwdata[tod_pkg::DEB_W-1:0];
        end
        default: begin
          thr_nxt = thr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= tod_pkg::THR_RESET;
      thr_sq_r <= tod_pkg::THR_SQ_RESET;
      deb_r    <= tod_pkg::DEB_RESET;
    end else begin
      thr_r    <= thr_nxt;
      thr_sq_r <= thr_sq_nxt;
      deb_r    <= deb_nxt;
    end
  end

  // read back, zero on an unaligned address
  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        tod_pkg::REG_FLAT_THRESHOLD: prdata = {{(32-tod_pkg::THR_W){1'b0}}, thr_r};
        tod_pkg::REG_DEBOUNCE_COUNT: prdata = {{(32-tod_pkg::DEB_W){1'b0}}, deb_r};
        default:                     prdata = 32'd0;
      endcase
    end
  end

  assign cfg.thr_sq   = thr_sq_r;
  assign cfg.debounce = deb_r;

endmodule
`default_nettype wire

// ===== design/tod_front.sv =====
`default_nettype none
module tod_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]      in_gravity_x,
  input  wire logic signed [SAMPLE_BITS-1:0]      in_gravity_y,
  input  wire logic [tod_pkg::THR_SQ_W-1:0]       thr_sq,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output tod_pkg::tod_class_t                     q_data
);

  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS - 1;
  localparam int unsigned MAG_W = 2 * SAMPLE_BITS;
  localparam int unsigned CMP_W = (MAG_W > tod_pkg::THR_SQ_W) ? MAG_W : tod_pkg::THR_SQ_W;

  logic signed [2*SAMPLE_BITS-1:0] prod_x, prod_y;
  logic signed [SAMPLE_BITS:0]     xe, ye, nxe, nye;
  logic [1:0]                      quad;
  logic                            accept;

  logic            s1_valid_r, s1_valid_nxt;
  logic [SQ_W-1:0] sq_x_r, sq_y_r;
  logic [1:0]      quad_r;

  logic [MAG_W-1:0] mag;
  logic [CMP_W-1:0] mag_cmp, thr_cmp;

  assign in_ready = !s1_valid_r || !q_full;
  assign accept   = in_valid && in_ready;

  // squares of both axes
  assign prod_x = in_gravity_x * in_gravity_x;
  assign prod_y = in_gravity_y * in_gravity_y;

  // dominant axis and sign, ties go clockwise
  assign xe  = {in_gravity_x[SAMPLE_BITS-1], in_gravity_x};
  assign ye  = {in_gravity_y[SAMPLE_BITS-1], in_gravity_y};
  assign nxe = -xe;
  assign nye = -ye;

  always_comb begin
    if (ye > 0 && xe < ye && xe >= nye) begin
      quad = tod_pkg::ROT_0;
    end else if (xe > 0 && ye <= xe && ye > nxe) begin
      quad = tod_pkg::ROT_90;
    end else if (ye < 0 && xe <= nye && xe > ye) begin
      quad = tod_pkg::ROT_180;
    end else if (xe < 0 && ye >= xe && ye < nxe) begin
      quad = tod_pkg::ROT_270;
    end else begin
      quad = tod_pkg::ROT_0;
    end
  end

  // stage one register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_x_r <= prod_x[SQ_W-1:0];
      sq_y_r <= prod_y[SQ_W-1:0];
      quad_r <= quad;
    end
  end

  // flat test on the squared in-plane magnitude
  assign mag     = {1'b0, sq_x_r} + {1'b0, sq_y_r};
  assign mag_cmp = CMP_W'(mag);
  assign thr_cmp = CMP_W'(thr_sq);

  assign q_push      = s1_valid_r && !q_full;
  assign q_data.flat = mag_cmp < thr_cmp;
  assign q_data.quad = quad_r;

endmodule
`default_nettype wire

// ===== design/tod_queue.sv =====
`default_nettype none
module tod_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire tod_pkg::tod_class_t  push_data,
  output logic                      full,
  input  wire logic                 pop,
  output logic                      q_valid,
  output tod_pkg::tod_class_t       q_data
);

  tod_pkg::tod_class_t               mem [tod_pkg::QUEUE_DEPTH];
  logic [tod_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [tod_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [tod_pkg::QCNT_W-1:0]        count_r,  count_nxt;

  assign full    = count_r == tod_pkg::QCNT_W'(tod_pkg::QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_data  = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/tod_back.sv =====
`default_nettype none
`include "tilt_orientation_debouncer_top_assert.svh"
module tod_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire tod_pkg::tod_class_t         q_data,
  output logic                             pop,
  input  wire logic [tod_pkg::DEB_W-1:0]   debounce,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       out_rotation,
  output logic                             out_rotation_changed
);

  logic [1:0]              cur_r, cur_nxt;
  logic [1:0]              tgt_r, tgt_nxt;
  logic [tod_pkg::DEB_W-1:0] cnt_r, cnt_nxt;
  logic [tod_pkg::DEB_W:0]   cnt_inc;
  logic [1:0]              cand;
  logic                    commit;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_rotation_r;
  logic       out_changed_r;

  assign pop = q_valid && (!out_valid_r || out_ready);

  // flat readings hold the current rotation
  assign cand    = q_data.flat ? cur_r : q_data.quad;
  assign cnt_inc = {1'b0, cnt_r} + 1'b1;

  // debounce update
  always_comb begin
    cur_nxt = cur_r;
    tgt_nxt = tgt_r;
    cnt_nxt = cnt_r;
    commit  = 1'b0;
    if (pop) begin
      if (cand == cur_r) begin
        cnt_nxt = '0;
      end else if (cand == tgt_r) begin
        if (cnt_inc >= {1'b0, debounce}) begin
          cur_nxt = cand;
          cnt_nxt = '0;
          commit  = 1'b1;
        end else begin
          cnt_nxt = cnt_inc[tod_pkg::DEB_W-1:0];
        end
      end else begin
        tgt_nxt = cand;
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= tod_pkg::ROT_0;
      tgt_r <= tod_pkg::ROT_0;
      cnt_r <= '0;
    end else begin
      cur_r <= cur_nxt;
      tgt_r <= tgt_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rotation_r <= cur_nxt;
      out_changed_r  <= commit;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_rotation         = out_rotation_r;
  assign out_rotation_changed = out_changed_r;

  // checks
  `TOD_ASSERT(a_pop_fills_out, pop |=> out_valid_r, "popped beat did not reach output")
  `TOD_ASSERT(a_commit_moves, commit |=> (cur_r != $past(cur_r)), "commit kept old rotation")
  `TOD_ASSERT(a_out_tracks_cur, out_valid_r |-> (out_rotation_r == cur_r), "output rotation stale")

endmodule
`default_nettype wire
